// ----- src/fbr_pkg.sv -----
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared constants and types for the frequency-based replacement block.
// ----------------------------------------------------------------------------
package fbr_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int OCC_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [1:0] SEC_NONE   = 2'd0;
    localparam logic [1:0] SEC_NEW    = 2'd1;
    localparam logic [1:0] SEC_MIDDLE = 2'd2;
    localparam logic [1:0] SEC_OLD    = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_USE   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_SIZE     = 2'd2;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [1:0]        wr_sec;
    } t_mem_req;

endpackage

// ----- src/fbr_ifs.sv -----
// ----------------------------------------------------------------------------
// fbr interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface fbr_in_if import fbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [SLOT_W-1:0] slot_index;
    modport source (output valid, command, slot_index, input ready);
    modport sink   (input valid, command, slot_index, output ready);
endinterface

interface fbr_out_if import fbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] chosen_slot;
    logic              was_unused;
    modport source (output valid, chosen_slot, was_unused, input ready);
    modport sink   (input valid, chosen_slot, was_unused, output ready);
endinterface

interface fbr_cfg_if import fbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/fbr_slot_store.sv -----
// ----------------------------------------------------------------------------
// fbr_slot_store
// Per-slot memory: section, use count and last-use stamp, registered read.
// ----------------------------------------------------------------------------
module fbr_slot_store import fbr_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mem_req               i_req,
    input  logic [COUNT_WIDTH-1:0] i_wr_cnt,
    input  logic [STAMP_WIDTH-1:0] i_wr_stmp,
    output logic [1:0]             o_rd_sec,
    output logic [COUNT_WIDTH-1:0] o_rd_cnt,
    output logic [STAMP_WIDTH-1:0] o_rd_stmp
);

    localparam int ENT_W = 2 + COUNT_WIDTH + STAMP_WIDTH;

    logic [ENT_W-1:0]     mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_placed;
    logic [ENT_W-1:0]     r_rd_data;
    logic                 r_rd_placed;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= {i_req.wr_sec, i_wr_cnt, i_wr_stmp};
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // never-written entries read as unplaced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed    <= '0;
            r_rd_placed <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_placed[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_placed <= r_placed[i_req.rd_addr];
            end
        end
    end

    assign o_rd_sec  = r_rd_placed ? r_rd_data[ENT_W-1 -: 2] : SEC_NONE;
    assign o_rd_cnt  = r_rd_data[STAMP_WIDTH +: COUNT_WIDTH];
    assign o_rd_stmp = r_rd_data[STAMP_WIDTH-1:0];

endmodule

// ----- src/frequency_based_block_replacement.sv -----
// A fresh allocate or an out-of-range use goes straight to the result; an in-range use
// first rewrites its slot entry, and a use may cascade into up to two section scans.
// Throughput: one command at a time; each scan walks all 64 slot entries through
// the single read port of the slot memory, one entry per cycle.
// Reset (synchronous, active low) empties all sections and restores the registers.
// ----------------------------------------------------------------------------
// frequency_based_block_replacement
// Frequency-based cache replacement with new, middle and old recency sections.
// ----------------------------------------------------------------------------
module frequency_based_block_replacement import fbr_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbr_in_if.sink     i_in,
    fbr_out_if.source  o_out,
    fbr_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_CHK1, S_CHK2, S_SCAN, S_MOVE, S_DONE
    } t_state;

    typedef enum logic [1:0] {K_NEW, K_MID, K_EVICT} t_kind;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    t_state                 r_state;
    t_kind                  r_kind;
    logic [OCC_W-1:0]       r_slots_in_use;
    logic [5:0]             r_new_size, r_old_size;
    logic [OCC_W-1:0]       r_filled, r_new_occ, r_mid_occ, r_old_occ;
    logic [STAMP_WIDTH-1:0] r_clock;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      r_res_slot;
    logic                   r_res_unused;
    logic [OCC_W-1:0]       r_addr;
    logic                   r_pend;
    logic [SLOT_W-1:0]      r_pidx;
    logic                   r_found;
    logic [SLOT_W-1:0]      r_best;
    logic [COUNT_WIDTH-1:0] r_bcnt;
    logic [STAMP_WIDTH-1:0] r_bstmp;
    logic                   r_out_valid;
    logic [SLOT_W-1:0]      r_out_slot;
    logic                   r_out_unused;

    t_mem_req               mreq;
    logic [COUNT_WIDTH-1:0] wr_cnt;
    logic [STAMP_WIDTH-1:0] wr_stmp;
    logic [1:0]             rd_sec;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [STAMP_WIDTH-1:0] rd_stmp;

    logic [OCC_W-1:0]       n_eff;
    logic [OCC_W:0]         size_sum;
    logic [OCC_W:0]         mid_cap;
    logic [1:0]             scan_sec;
    logic                   better;
    logic                   in_acc;

    fbr_slot_store #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .STAMP_WIDTH(STAMP_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mreq),
        .i_wr_cnt  (wr_cnt),
        .i_wr_stmp (wr_stmp),
        .o_rd_sec  (rd_sec),
        .o_rd_cnt  (rd_cnt),
        .o_rd_stmp (rd_stmp)
    );

    assign n_eff    = (r_slots_in_use > OCC_W'(NUM_SLOTS)) ? OCC_W'(NUM_SLOTS) : r_slots_in_use;
    assign size_sum = {2'b00, r_new_size} + {2'b00, r_old_size};
    assign mid_cap  = ({1'b0, n_eff} > size_sum) ? ({1'b0, n_eff} - size_sum) : '0;
    assign in_acc   = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.chosen_slot = r_out_slot;
    assign o_out.was_unused  = r_out_unused;

    always_comb begin
        case (r_kind)
            K_NEW:   scan_sec = SEC_NEW;
            K_MID:   scan_sec = SEC_MIDDLE;
            K_EVICT: scan_sec = SEC_OLD;
            default: scan_sec = SEC_OLD;
        endcase
    end

    // candidate beats current best: lowest stamp, or lowest (count, stamp) on evict
    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (r_kind == K_EVICT) begin
            better = (rd_cnt < r_bcnt) || ((rd_cnt == r_bcnt) && (rd_stmp < r_bstmp));
        end else begin
            better = rd_stmp < r_bstmp;
        end
    end

    always_comb begin
        mreq    = '0;
        wr_cnt  = r_bcnt;
        wr_stmp = r_bstmp;
        case (r_state)
            S_IDLE: begin
                mreq.rd_en   = in_acc;
                mreq.rd_addr = i_in.slot_index;
            end
            S_UPD: begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = r_slot;
                mreq.wr_sec  = SEC_NEW;
                wr_stmp      = r_clock;
                if (rd_sec == SEC_NONE) begin
                    wr_cnt = '0;
                end else if (rd_sec != SEC_NEW && rd_cnt != CNT_MAX) begin
                    wr_cnt = rd_cnt + 1'b1;
                end else begin
                    wr_cnt = rd_cnt;
                end
            end
            S_SCAN: begin
                mreq.rd_en   = !r_addr[OCC_W-1];
                mreq.rd_addr = r_addr[SLOT_W-1:0];
            end
            S_MOVE: begin
                mreq.wr_en   = r_found;
                mreq.wr_addr = r_best;
                case (r_kind)
                    K_NEW:   mreq.wr_sec = SEC_MIDDLE;
                    K_MID:   mreq.wr_sec = SEC_OLD;
                    K_EVICT: mreq.wr_sec = SEC_NONE;
                    default: mreq.wr_sec = SEC_NONE;
                endcase
                if (r_kind == K_EVICT) begin
                    wr_cnt = '0;
                end
            end
            default: begin
                mreq = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_kind         <= K_NEW;
            r_slots_in_use <= 7'd64;
            r_new_size     <= 6'd16;
            r_old_size     <= 6'd16;
            r_filled       <= '0;
            r_new_occ      <= '0;
            r_mid_occ      <= '0;
            r_old_occ      <= '0;
            r_clock        <= '0;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_found        <= 1'b0;
            r_addr         <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_SLOTS_IN_USE: r_slots_in_use <= i_cfg.data;
                    REG_NEW_SIZE:     r_new_size     <= i_cfg.data[5:0];
                    REG_OLD_SIZE:     r_old_size     <= i_cfg.data[5:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_slot <= i_in.slot_index;
                        if (i_in.command == CMD_ALLOC) begin
                            if (r_filled < n_eff) begin
                                r_res_slot   <= r_filled[SLOT_W-1:0];
                                r_res_unused <= 1'b1;
                                r_filled     <= r_filled + 1'b1;
                                r_state      <= S_DONE;
                            end else begin
                                r_kind  <= K_EVICT;
                                r_addr  <= '0;
                                r_found <= 1'b0;
                                r_state <= S_SCAN;
                            end
                        end else if ({1'b0, i_in.slot_index} >= n_eff) begin
                            r_res_slot   <= i_in.slot_index;
                            r_res_unused <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_res_slot   <= i_in.slot_index;
                            r_res_unused <= 1'b0;
                            r_state      <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_clock <= r_clock + 1'b1;
                    if (rd_sec == SEC_NEW) begin
                        r_state <= S_DONE;
                    end else begin
                        if (rd_sec == SEC_MIDDLE && r_mid_occ != '0) begin
                            r_mid_occ <= r_mid_occ - 1'b1;
                        end
                        if (rd_sec == SEC_OLD && r_old_occ != '0) begin
                            r_old_occ <= r_old_occ - 1'b1;
                        end
                        r_new_occ <= r_new_occ + 1'b1;
                        r_state   <= S_CHK1;
                    end
                end
                S_CHK1: begin
                    if (r_new_occ > {1'b0, r_new_size}) begin
                        r_kind  <= K_NEW;
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_CHK2;
                    end
                end
                S_CHK2: begin
                    if ({1'b0, r_mid_occ} > mid_cap) begin
                        r_kind  <= K_MID;
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    r_pend <= !r_addr[OCC_W-1];
                    r_pidx <= r_addr[SLOT_W-1:0];
                    if (!r_addr[OCC_W-1]) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_pend && rd_sec == scan_sec && better) begin
                        r_found <= 1'b1;
                        r_best  <= r_pidx;
                        r_bcnt  <= rd_cnt;
                        r_bstmp <= rd_stmp;
                    end
                    if (r_addr[OCC_W-1] && !r_pend) begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_pend <= 1'b0;
                    case (r_kind)
                        K_NEW: begin
                            if (r_found) begin
                                if (r_new_occ != '0) begin
                                    r_new_occ <= r_new_occ - 1'b1;
                                end
                                r_mid_occ <= r_mid_occ + 1'b1;
                            end
                            r_state <= S_CHK2;
                        end
                        K_MID: begin
                            if (r_found) begin
                                if (r_mid_occ != '0) begin
                                    r_mid_occ <= r_mid_occ - 1'b1;
                                end
                                r_old_occ <= r_old_occ + 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            if (r_found) begin
                                if (r_old_occ != '0) begin
                                    r_old_occ <= r_old_occ - 1'b1;
                                end
                                r_res_slot <= r_best;
                            end else begin
                                r_res_slot <= '0;
                            end
                            r_res_unused <= 1'b0;
                            r_state      <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_slot   <= r_res_slot;
                        r_out_unused <= r_res_unused;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/frequency_based_block_replacement_test.sv -----
// ----------------------------------------------------------------------------
// frequency_based_block_replacement_test
// Self-checking bench: a software copy of the replacement policy predicts
// each result; commands run under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module frequency_based_block_replacement_test;
    import fbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_WIDTH   = 16;
    localparam int STAMP_WIDTH   = 32;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              unused;
    } t_grant;

    logic i_clk;
    logic i_rst_n;

    fbr_in_if  cmd_ch ();
    fbr_out_if grant_ch ();
    fbr_cfg_if cfg_ch ();

    frequency_based_block_replacement #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (grant_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // policy state
    logic [6:0]             pol_slots;
    logic [5:0]             pol_new_size;
    logic [5:0]             pol_old_size;
    logic [1:0]             pol_sec   [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] pol_count [NUM_SLOTS];
    logic [STAMP_WIDTH-1:0] pol_stamp [NUM_SLOTS];
    logic [STAMP_WIDTH-1:0] pol_clock;
    int                     pol_filled;
    int                     occ_new, occ_mid, occ_old;

    t_grant grants_due[$];
    int     mismatches;
    int     grants_seen;
    int     allocs_sent, uses_sent;
    int     idle_in_pct, stall_out_pct;
    int     quiet_cycles;

    function automatic int active_slots();
        return (pol_slots > NUM_SLOTS) ? NUM_SLOTS : int'(pol_slots);
    endfunction

    function automatic void occ_adjust(logic [1:0] sec, int delta);
        if (sec == SEC_NEW) begin
            if (delta > 0 || occ_new > 0) occ_new += delta;
        end else if (sec == SEC_MIDDLE) begin
            if (delta > 0 || occ_mid > 0) occ_mid += delta;
        end else if (sec == SEC_OLD) begin
            if (delta > 0 || occ_old > 0) occ_old += delta;
        end
    endfunction

    function automatic void move_slot(int s, logic [1:0] to);
        occ_adjust(pol_sec[s], -1);
        occ_adjust(to, 1);
        pol_sec[s] = to;
    endfunction

    function automatic int oldest_in(logic [1:0] sec);
        int best;
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pol_sec[i] == sec && (best < 0 || pol_stamp[i] < pol_stamp[best])) best = i;
        end
        return best;
    endfunction

    function automatic void reset_policy();
        pol_slots    = 7'd64;
        pol_new_size = 6'd16;
        pol_old_size = 6'd16;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pol_sec[i]   = SEC_NONE;
            pol_count[i] = '0;
            pol_stamp[i] = '0;
        end
        pol_clock  = '0;
        pol_filled = 0;
        occ_new    = 0;
        occ_mid    = 0;
        occ_old    = 0;
    endfunction

    function automatic t_grant predict_grant(logic cmd, logic [SLOT_W-1:0] s);
        t_grant g;
        int     n, best, v, mid;
        n = active_slots();
        if (cmd == CMD_ALLOC) begin
            if (pol_filled < n) begin
                g.slot   = pol_filled[SLOT_W-1:0];
                g.unused = 1'b1;
                pol_filled++;
            end else begin
                best = -1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pol_sec[i] != SEC_OLD) continue;
                    if (best < 0 || pol_count[i] < pol_count[best] ||
                        (pol_count[i] == pol_count[best] && pol_stamp[i] < pol_stamp[best]))
                        best = i;
                end
                g.unused = 1'b0;
                if (best < 0) begin
                    g.slot = '0;
                end else begin
                    move_slot(best, SEC_NONE);
                    pol_count[best] = '0;
                    g.slot = best[SLOT_W-1:0];
                end
            end
            return g;
        end
        g.slot   = s;
        g.unused = 1'b0;
        if (int'(s) >= n) return g;
        pol_stamp[s] = pol_clock;
        if (pol_sec[s] != SEC_NEW) begin
            if (pol_sec[s] == SEC_NONE) pol_count[s] = '0;
            else if (pol_count[s] != '1) pol_count[s] = pol_count[s] + 1'b1;
            move_slot(s, SEC_NEW);
            mid = n - int'(pol_new_size) - int'(pol_old_size);
            if (mid < 0) mid = 0;
            if (occ_new > int'(pol_new_size)) begin
                v = oldest_in(SEC_NEW);
                if (v >= 0) move_slot(v, SEC_MIDDLE);
            end
            if (occ_mid > mid) begin
                v = oldest_in(SEC_MIDDLE);
                if (v >= 0) move_slot(v, SEC_OLD);
            end
        end
        pol_clock = pol_clock + 1'b1;
        return g;
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && grant_ch.valid && grant_ch.ready) begin
            grants_seen++;
            if (grants_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slot %0d unused %0b",
                             grant_ch.chosen_slot, grant_ch.was_unused);
            end else begin
                want = grants_due.pop_front();
                if (grant_ch.chosen_slot !== want.slot || grant_ch.was_unused !== want.unused) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected slot %0d unused %0b, got slot %0d unused %0b",
                                 want.slot, want.unused, grant_ch.chosen_slot,
                                 grant_ch.was_unused);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        grant_ch.ready <= ($urandom_range(99) >= stall_out_pct);
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (grant_ch.valid && grant_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // valid drops on the falling edge after the transaction; the block is busy then anyway
    task automatic send_command(logic cmd, logic [SLOT_W-1:0] s);
        while ($urandom_range(99) < idle_in_pct) @(negedge i_clk);
        grants_due.push_back(predict_grant(cmd, s));
        if (cmd == CMD_ALLOC) allocs_sent++;
        else uses_sent++;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.slot_index <= s;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (grants_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_SLOTS_IN_USE) pol_slots = val;
        else if (idx == REG_NEW_SIZE) pol_new_size = val[5:0];
        else if (idx == REG_OLD_SIZE) pol_old_size = val[5:0];
    endtask

    task automatic set_regs(int slots, int new_sz, int old_sz);
        write_reg(REG_SLOTS_IN_USE, CFG_DAT_W'(slots));
        write_reg(REG_NEW_SIZE, CFG_DAT_W'(new_sz));
        write_reg(REG_OLD_SIZE, CFG_DAT_W'(old_sz));
    endtask

    // uses drawn mostly from the managed range, sometimes hot slots
    function automatic logic [SLOT_W-1:0] pick_slot();
        int n;
        n = active_slots();
        case ($urandom_range(9))
            0: return SLOT_W'($urandom_range(63));
            1, 2: return SLOT_W'($urandom_range(n < 4 ? n - 1 : 3));
            default: return SLOT_W'($urandom_range(n - 1));
        endcase
    endfunction

    task automatic random_traffic(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 30) send_command(CMD_ALLOC, SLOT_W'($urandom));
            else send_command(CMD_USE, pick_slot());
        end
    endtask

    task automatic test_directed();
        idle_in_pct   = 0;
        stall_out_pct = 0;
        // out-of-range use, then fill, use and evict
        send_command(CMD_USE, 6'd63);
        for (int i = 0; i < 6; i++) send_command(CMD_ALLOC, 6'd0);
        send_command(CMD_USE, 6'd0);
        send_command(CMD_USE, 6'd0);
        send_command(CMD_USE, 6'd5);
        send_command(CMD_USE, 6'd3);
        send_command(CMD_USE, 6'd1);
        send_command(CMD_USE, 6'd2);
        send_command(CMD_USE, 6'd4);
        send_command(CMD_USE, 6'd5);
        send_command(CMD_USE, 6'd6);
        send_command(CMD_USE, 6'd63);
        send_command(CMD_ALLOC, 6'd63);
        send_command(CMD_ALLOC, 6'd42);
        send_command(CMD_USE, 6'd0);
        send_command(CMD_ALLOC, 6'd0);
    endtask

    task automatic test_small_cache();
        // tiny sections, zero new section, old section larger than cache
        set_regs(6, 2, 2);
        random_traffic(120);
        set_regs(4, 0, 1);
        random_traffic(100);
        set_regs(3, 1, 62);
        random_traffic(80);
        set_regs(1, 62, 1);
        random_traffic(60);
    endtask

    task automatic test_idle_phases();
        set_regs(12, 3, 4);
        idle_in_pct   = 60;
        stall_out_pct = 0;
        random_traffic(250);
        idle_in_pct   = 0;
        stall_out_pct = 60;
        set_regs(20, 5, 6);
        random_traffic(250);
        idle_in_pct   = 18;
        stall_out_pct = 18;
        random_traffic(200);
        idle_in_pct   = 0;
        stall_out_pct = 0;
    endtask

    task automatic test_full_size();
        // oversized register, then shrink sections under a full cache
        set_regs(127, 16, 16);
        random_traffic(200);
        set_regs(64, 1, 62);
        random_traffic(120);
        set_regs(64, 62, 1);
        random_traffic(120);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_ALLOC;
        cmd_ch.slot_index = '0;
        grant_ch.ready    = 1'b1;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_SLOTS_IN_USE;
        cfg_ch.data       = '0;
        mismatches        = 0;
        grants_seen       = 0;
        allocs_sent       = 0;
        uses_sent         = 0;
        idle_in_pct       = 0;
        stall_out_pct     = 0;
        quiet_cycles      = 0;
        reset_policy();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        set_regs(7, 2, 2);
        test_directed();
        test_small_cache();
        test_idle_phases();
        test_full_size();
        wait_drained();
        $display("Covered %0d allocates and %0d uses over %0d results,", allocs_sent,
                 uses_sent, grants_seen);
        $display("with sizes from one slot up to an oversized count and mixed idle phases.");
        if (mismatches == 0 && grants_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
